/* hw/rtl/bgc_pkg.sv */
// Shared types and constants for the button gesture classifier.
`default_nettype none
package bgc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned GestW  = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [GestW-1:0] GEST_NONE         = 3'd0;
  localparam logic [GestW-1:0] GEST_SINGLE_CLICK = 3'd1;
  localparam logic [GestW-1:0] GEST_SINGLE_HOLD  = 3'd2;
  localparam logic [GestW-1:0] GEST_DOUBLE_CLICK = 3'd3;
  localparam logic [GestW-1:0] GEST_DOUBLE_HOLD  = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_HOLD_TIME = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CLICK_GAP = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE  = 2'd2;

  localparam logic [TimeW-1:0] HOLD_TIME_RST = 32'd1000;
  localparam logic [TimeW-1:0] CLICK_GAP_RST = 32'd300;
  localparam logic [TimeW-1:0] DEBOUNCE_RST  = 32'd50;

  localparam logic [TimeW-1:0] TIME_ONE = 32'd1;

  typedef struct packed {
    logic [TimeW-1:0] hold_time_ms;
    logic [TimeW-1:0] click_gap_ms;
    logic [TimeW-1:0] debounce_ms;
  } cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/bgc_in_if.sv */
// Input sample channel: level and millisecond timestamp.
`default_nettype none
interface bgc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         level;
  logic [bgc_pkg::TimeW-1:0]    now_ms;

  modport source (output valid, output level, output now_ms, input ready);
  modport sink   (input valid, input level, input now_ms, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bgc_out_if.sv */
// Result channel: one gesture code per sample.
`default_nettype none
interface bgc_out_if;
  logic                         valid;
  logic                         ready;
  logic [bgc_pkg::GestW-1:0]    gesture;

  modport source (output valid, output gesture, input ready);
  modport sink   (input valid, input gesture, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bgc_cfg_if.sv */
// Configuration write channel: register index and write data.
`default_nettype none
interface bgc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bgc_pkg::CfgIdxW-1:0]  idx;
  logic [bgc_pkg::TimeW-1:0]    wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bgc_cfg_regs.sv */
// Configuration register file: hold time, click gap and debounce time.
`default_nettype none
module bgc_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst_n,
  bgc_cfg_if.sink             cfg_ch,
  output bgc_pkg::cfg_t       cfg
);

  bgc_pkg::cfg_t cfg_r;
  bgc_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        bgc_pkg::REG_HOLD_TIME: cfg_nxt.hold_time_ms = cfg_ch.wdata;
        bgc_pkg::REG_CLICK_GAP: cfg_nxt.click_gap_ms = cfg_ch.wdata;
        bgc_pkg::REG_DEBOUNCE:  cfg_nxt.debounce_ms  = cfg_ch.wdata;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_time_ms <= bgc_pkg::HOLD_TIME_RST;
      cfg_r.click_gap_ms <= bgc_pkg::CLICK_GAP_RST;
      cfg_r.debounce_ms  <= bgc_pkg::DEBOUNCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bgc_step.sv */
// Gesture decision logic and the classifier state it updates per sample.
`default_nettype none
module bgc_step (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       advance,
  input  wire logic                       level,
  input  wire logic [bgc_pkg::TimeW-1:0]  now_ms,
  input  wire bgc_pkg::cfg_t              cfg,
  output logic      [bgc_pkg::GestW-1:0]  gesture
);

  logic                       prev_level_r, prev_level_nxt;
  logic [bgc_pkg::TimeW-1:0]  first_rel_r, first_rel_nxt;
  logic [bgc_pkg::TimeW-1:0]  rise_time_r, rise_time_nxt;
  logic [bgc_pkg::TimeW-1:0]  deb_start_r, deb_start_nxt;
  logic                       armed_r, armed_nxt;
  logic [bgc_pkg::GestW-1:0]  last_event_r, last_event_nxt;

  logic [bgc_pkg::TimeW-1:0]  since_rel;
  logic [bgc_pkg::TimeW-1:0]  since_rise;
  logic [bgc_pkg::TimeW-1:0]  since_deb;
  logic                       pending;

  assign pending    = (first_rel_r != '0);
  assign since_rel  = now_ms - first_rel_r;
  assign since_rise = now_ms - rise_time_nxt;
  assign since_deb  = now_ms - deb_start_r;

  always_comb begin
    prev_level_nxt = level;
    first_rel_nxt  = first_rel_r;
    rise_time_nxt  = (level && !prev_level_r) ? now_ms : rise_time_r;
    deb_start_nxt  = deb_start_r;
    armed_nxt      = armed_r;
    last_event_nxt = bgc_pkg::GEST_NONE;
    gesture        = bgc_pkg::GEST_NONE;

    if (level && armed_r && (since_rel > cfg.hold_time_ms)) begin
      first_rel_nxt  = bgc_pkg::TIME_ONE;
      last_event_nxt = bgc_pkg::GEST_DOUBLE_HOLD;
      gesture        = bgc_pkg::GEST_DOUBLE_HOLD;
    end else if (pending && !level && (since_rel > cfg.click_gap_ms)) begin
      first_rel_nxt  = '0;
      armed_nxt      = 1'b0;
      last_event_nxt = last_event_r;
      gesture        = (last_event_r == bgc_pkg::GEST_DOUBLE_HOLD) ?
                       bgc_pkg::GEST_NONE : bgc_pkg::GEST_SINGLE_CLICK;
    end else if (!pending && level && (since_rise > cfg.hold_time_ms)) begin
      last_event_nxt = bgc_pkg::GEST_SINGLE_HOLD;
      gesture        = bgc_pkg::GEST_SINGLE_HOLD;
    end else if ((level != prev_level_r) && !(since_deb < cfg.debounce_ms)) begin
      deb_start_nxt = now_ms;
      if (!level && pending) begin
        first_rel_nxt  = '0;
        armed_nxt      = 1'b0;
        last_event_nxt = bgc_pkg::GEST_DOUBLE_CLICK;
        gesture        = bgc_pkg::GEST_DOUBLE_CLICK;
      end else if (!level && (last_event_r != bgc_pkg::GEST_SINGLE_HOLD)) begin
        armed_nxt     = 1'b1;
        first_rel_nxt = (now_ms == '0) ? bgc_pkg::TIME_ONE : now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      first_rel_r  <= '0;
      rise_time_r  <= '0;
      deb_start_r  <= '0;
      armed_r      <= 1'b0;
      last_event_r <= bgc_pkg::GEST_NONE;
    end else if (advance) begin
      prev_level_r <= prev_level_nxt;
      first_rel_r  <= first_rel_nxt;
      rise_time_r  <= rise_time_nxt;
      deb_start_r  <= deb_start_nxt;
      armed_r      <= armed_nxt;
      last_event_r <= last_event_nxt;
    end
  end

  a_armed_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (first_rel_r != '0))
    else $error("armed without a pending release time");

  a_prev_tracks_level: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (prev_level_r == $past(level)))
    else $error("previous level did not take the sample");

  a_dhold_records: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (gesture == bgc_pkg::GEST_DOUBLE_HOLD)) |=>
    (last_event_r == bgc_pkg::GEST_DOUBLE_HOLD) && (first_rel_r == bgc_pkg::TIME_ONE))
    else $error("double hold did not update state");

  a_click_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (gesture == bgc_pkg::GEST_SINGLE_CLICK ||
                 gesture == bgc_pkg::GEST_DOUBLE_CLICK)) |=>
    (first_rel_r == '0) && !armed_r)
    else $error("click did not clear the pending release");

endmodule
`default_nettype wire

/* hw/rtl/button_gesture_classifier_core.sv */
// Top level of the button gesture classifier: input register, decision step, result register.
//
//   channel  dir  payload                          beat when
//   in_ch    in   level[0], now_ms[31:0]           valid && ready
//   out_ch   out  gesture[2:0]                     valid && ready
//   cfg_ch   in   idx[1:0], wdata[31:0]            valid && ready (ready tied high)
//
// The input register and then the result register lie between an input beat and its result;
// one sample per cycle sustained while the result side is ready.
// The decision step between the input register and the result register sets that rate.
// Synchronous active-low reset restores register defaults and clears step and valid state.
// A stalled result holds the step; the input register still takes one more beat.
`default_nettype none
module button_gesture_classifier_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bgc_in_if.sink      in_ch,
  bgc_out_if.source   out_ch,
  bgc_cfg_if.sink     cfg_ch
);

  bgc_pkg::cfg_t              cfg;

  logic                       in_valid_r, in_valid_nxt;
  logic                       in_level_r;
  logic [bgc_pkg::TimeW-1:0]  in_now_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [bgc_pkg::GestW-1:0]  out_gesture_r;
  logic [bgc_pkg::GestW-1:0]  step_gesture;
  logic                       advance;
  logic                       in_beat;

  assign advance        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready    = !in_valid_r || advance;
  assign in_beat        = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.gesture = out_gesture_r;

  bgc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  bgc_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .level   (in_level_r),
    .now_ms  (in_now_r),
    .cfg     (cfg),
    .gesture (step_gesture)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_beat) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      in_level_r <= in_ch.level;
      in_now_r   <= in_ch.now_ms;
    end
    if (advance) begin
      out_gesture_r <= step_gesture;
    end
  end

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_gesture_r <= bgc_pkg::GEST_DOUBLE_HOLD))
    else $error("gesture code out of range");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && (out_gesture_r == $past(step_gesture)))
    else $error("result register missed a step");

  a_stall_blocks_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !advance)
    else $error("step advanced over a stalled result");

endmodule
`default_nettype wire

/* tb/button_gesture_classifier_core_tb.sv */
// Testbench for button_gesture_classifier_core: self-checking gesture prediction per sample.
`timescale 1ns / 1ps
module button_gesture_classifier_core_tb;

  localparam logic [bgc_pkg::CfgIdxW-1:0] REG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    logic                      level;
    logic [bgc_pkg::TimeW-1:0] now_ms;
    int                        gap;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n;

  bgc_in_if  in_ch();
  bgc_out_if out_ch();
  bgc_cfg_if cfg_ch();

  button_gesture_classifier_core DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #10 clk = ~clk;

  // gesture predictor state and register copies
  logic [bgc_pkg::TimeW-1:0] hold_ms, gap_ms, debounce_ms;
  logic                      pv_level;
  logic [bgc_pkg::TimeW-1:0] pend_release, rise_t, deb_start;
  logic                      dh_armed;
  logic [bgc_pkg::GestW-1:0] last_gest;

  sample_t                   sample_q[$];
  logic [bgc_pkg::GestW-1:0] gesture_q[$];
  sample_t                   cur;
  logic                      drv_active;
  bit                        src_idle, snk_idle, hold_req;
  int                        snk_wait, hold_left, stall_cycles;
  int                        errors, samples_sent, results_seen, cfg_writes;
  int                        gest_hits[0:7];

  function automatic logic [bgc_pkg::GestW-1:0] predict_gesture(
      input logic lvl, input logic [bgc_pkg::TimeW-1:0] now);
    logic [bgc_pkg::TimeW-1:0] since_rel, since_rise, since_deb;
    logic [bgc_pkg::GestW-1:0] g;
    if (lvl && !pv_level) rise_t = now;
    since_rel  = now - pend_release;
    since_rise = now - rise_t;
    since_deb  = now - deb_start;
    g = bgc_pkg::GEST_NONE;
    if (lvl && since_rel > hold_ms && dh_armed) begin
      pend_release = bgc_pkg::TIME_ONE;
      g = bgc_pkg::GEST_DOUBLE_HOLD;
      last_gest = g;
    end else if (pend_release != '0 && since_rel > gap_ms && !lvl) begin
      pend_release = '0;
      dh_armed = 1'b0;
      g = (last_gest == bgc_pkg::GEST_DOUBLE_HOLD) ? bgc_pkg::GEST_NONE :
                                                     bgc_pkg::GEST_SINGLE_CLICK;
    end else if (pend_release == '0 && since_rise > hold_ms && lvl) begin
      g = bgc_pkg::GEST_SINGLE_HOLD;
      last_gest = g;
    end else begin
      if (lvl != pv_level && since_deb >= debounce_ms) begin
        deb_start = now;
        if (!lvl) begin
          if (pend_release != '0) begin
            pend_release = '0;
            dh_armed = 1'b0;
            g = bgc_pkg::GEST_DOUBLE_CLICK;
          end else if (last_gest != bgc_pkg::GEST_SINGLE_HOLD) begin
            dh_armed = 1'b1;
            pend_release = (now == '0) ? bgc_pkg::TIME_ONE : now;
          end
        end
      end
      last_gest = g;
    end
    pv_level = lvl;
    return g;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      drv_active = 1'b0;
    end else begin
      if (drv_active && in_ch.ready) begin
        gesture_q.push_back(predict_gesture(cur.level, cur.now_ms));
        samples_sent++;
        drv_active = 1'b0;
      end
      if (!drv_active && sample_q.size() > 0) begin
        if (sample_q[0].gap > 0) begin
          sample_q[0].gap--;
        end else begin
          cur = sample_q.pop_front();
          in_ch.level  <= cur.level;
          in_ch.now_ms <= cur.now_ms;
          drv_active = 1'b1;
        end
      end
      in_ch.valid <= drv_active;
    end
  end

  // gesture monitor
  always @(posedge clk) begin
    logic                      rdy;
    logic [bgc_pkg::GestW-1:0] exp_g;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_wait = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.gesture < 8) gest_hits[out_ch.gesture]++;
        if (gesture_q.size() == 0) begin
          $display("%0t: unexpected gesture beat, expected none, got %0d",
                   $time, out_ch.gesture);
          errors++;
        end else begin
          exp_g = gesture_q.pop_front();
          if (out_ch.gesture !== exp_g) begin
            $display("%0t: gesture mismatch, expected %0d, got %0d",
                     $time, exp_g, out_ch.gesture);
            errors++;
          end
        end
        snk_wait = snk_idle ? $urandom_range(0, 4) : 0;
      end
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  // watchdog: end the run if no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic queue_sample(input logic lvl, input logic [bgc_pkg::TimeW-1:0] now);
    sample_t s;
    s.level  = lvl;
    s.now_ms = now;
    s.gap    = src_idle ? $urandom_range(0, 4) : 0;
    sample_q.push_back(s);
  endtask

  task automatic write_reg(input logic [bgc_pkg::CfgIdxW-1:0] idx,
                           input logic [bgc_pkg::TimeW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      bgc_pkg::REG_HOLD_TIME: hold_ms = val;
      bgc_pkg::REG_CLICK_GAP: gap_ms = val;
      bgc_pkg::REG_DEBOUNCE:  debounce_ms = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(input logic [bgc_pkg::TimeW-1:0] h,
                            input logic [bgc_pkg::TimeW-1:0] g,
                            input logic [bgc_pkg::TimeW-1:0] d);
    write_reg(bgc_pkg::REG_HOLD_TIME, h);
    write_reg(bgc_pkg::REG_CLICK_GAP, g);
    write_reg(bgc_pkg::REG_DEBOUNCE, d);
    write_reg(REG_SPARE, $urandom());
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || drv_active || gesture_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // walk time forward in steps, some of which straddle the configured thresholds
  task automatic gen_walk(input int count);
    logic                      lvl;
    logic [bgc_pkg::TimeW-1:0] t, dt;
    int                        pick;
    t   = $urandom();
    lvl = 1'($urandom_range(0, 1));
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 39) begin
        src_idle = 1'($urandom_range(0, 1));
        snk_idle = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 13);
      case (pick)
        0:       dt = '0;
        1:       dt = $urandom_range(1, 8);
        2, 3:    dt = debounce_ms - 1 + $urandom_range(0, 2);
        4, 5:    dt = gap_ms - 1 + $urandom_range(0, 2);
        6, 7:    dt = hold_ms - 1 + $urandom_range(0, 2);
        13:      dt = $urandom();
        default: dt = $urandom_range(0, 60);
      endcase
      t = t + dt;
      if ($urandom_range(0, 4) < 2) lvl = ~lvl;
      queue_sample(lvl, t);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.level = 1'b0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = bgc_pkg::REG_HOLD_TIME;
    cfg_ch.wdata = '0;
    hold_ms = bgc_pkg::HOLD_TIME_RST;
    gap_ms = bgc_pkg::CLICK_GAP_RST;
    debounce_ms = bgc_pkg::DEBOUNCE_RST;
    pv_level = 1'b0;
    pend_release = '0;
    rise_t = '0;
    deb_start = '0;
    dh_armed = 1'b0;
    last_gest = bgc_pkg::GEST_NONE;
    drv_active = 1'b0;
    hold_req = 1'b0;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    errors = 0;
    samples_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    foreach (gest_hits[i]) gest_hits[i] = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: double click, single click, double hold then timeout,
    // repeated single hold, hold blocking the arm, time zero and wrap
    queue_sample(1'b0, 32'd0);
    queue_sample(1'b1, 32'd100);
    queue_sample(1'b0, 32'd200);
    queue_sample(1'b1, 32'd220);
    queue_sample(1'b1, 32'd230);
    queue_sample(1'b0, 32'd300);
    queue_sample(1'b1, 32'd400);
    queue_sample(1'b0, 32'd500);
    queue_sample(1'b0, 32'd801);
    queue_sample(1'b1, 32'd900);
    queue_sample(1'b0, 32'd1000);
    queue_sample(1'b1, 32'd1100);
    queue_sample(1'b1, 32'd2001);
    queue_sample(1'b0, 32'd2100);
    queue_sample(1'b1, 32'd2200);
    queue_sample(1'b1, 32'd3201);
    queue_sample(1'b1, 32'd3300);
    queue_sample(1'b0, 32'd3400);
    queue_sample(1'b1, 32'hFFFF_FF00);
    queue_sample(1'b0, 32'd0);
    queue_sample(1'b1, 32'd10);
    queue_sample(1'b0, 32'hFFFF_FFFF);
    drain();

    set_config(32'd40, 32'd15, 32'd3);
    gen_walk(200);
    drain();

    // zero thresholds; stall the result side while samples keep coming
    set_config('0, '0, '0);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    hold_req = 1'b1;
    gen_walk(150);
    drain();

    set_config('1, '1, '1);
    src_idle = 1'b1;
    snk_idle = 1'b1;
    gen_walk(130);
    drain();

    set_config($urandom_range(20, 400), $urandom_range(5, 200), $urandom_range(0, 30));
    gen_walk(200);
    drain();

    $display("Run covered %0d samples, %0d gesture beats, %0d register writes",
             samples_sent, results_seen, cfg_writes);
    $display("Gestures seen: none %0d, click %0d, hold %0d, double click %0d, double hold %0d",
             gest_hits[0], gest_hits[1], gest_hits[2], gest_hits[3], gest_hits[4]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bgc_pkg.sv
hw/rtl/bgc_in_if.sv
hw/rtl/bgc_out_if.sv
hw/rtl/bgc_cfg_if.sv
hw/rtl/bgc_cfg_regs.sv
hw/rtl/bgc_step.sv
hw/rtl/button_gesture_classifier_core.sv
tb/button_gesture_classifier_core_tb.sv
